// ===== hw/rtl/glzw_pkg.sv =====
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants of the GIF LZW encoder core.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MAX_CODES_DEF   = 4096;
  localparam int SYMBOL_BITS_DEF = 8;

  // code field width covers the largest dictionary
  localparam int CODE_W      = 12;
  localparam int WIDTH_W     = 4;
  localparam int EPOCH_W     = 10;
  localparam int NCODE       = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  // one request from front to back: up to four codes, optional final flush
  typedef struct packed {
    logic [NCODE-1:0][CODE_W-1:0]  code;
    logic [NCODE-1:0][WIDTH_W-1:0] width;
    logic [2:0]                    count;
    logic                          flush;
  } emit_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    FR_CLEAR,
    FR_RUN,
    FR_LOOK
  } front_state_t;

endpackage

// ===== hw/rtl/glzw_if.sv =====
// ----------------------------------------------------------------------------
// glzw channel interfaces
// Valid/ready channels for pixels in and packed bytes out.
// ----------------------------------------------------------------------------
interface glzw_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface glzw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/glzw_front.sv =====
// ----------------------------------------------------------------------------
// glzw_front
// Dictionary lookup and code selection; a new pixel waits for the last lookup.
// ----------------------------------------------------------------------------
module glzw_front #(
  parameter int MAX_CODES   = glzw_pkg::MAX_CODES_DEF,
  parameter int SYMBOL_BITS = glzw_pkg::SYMBOL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  glzw_pix_if.sink            pix_in,
  input  glzw_pkg::q_status_t q_status,
  output logic                push,
  output glzw_pkg::emit_t     push_entry
);
  import glzw_pkg::*;

  localparam int IDX_W  = $clog2(MAX_CODES);
  localparam int ADDR_W = IDX_W + SYMBOL_BITS;
  localparam int WORD_W = EPOCH_W + CODE_W;
  localparam int NFC_W  = CODE_W + 1;

  logic [WORD_W-1:0] dict [2**ADDR_W];

  front_state_t      state, state_next;
  logic [3:0]        min_size;
  logic [3:0]        active, active_next;
  logic              started, started_next;
  logic [CODE_W-1:0] cur, cur_next;
  logic [NFC_W-1:0]  nfc, nfc_next;
  logic [3:0]        cw, cw_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [ADDR_W-1:0] look_addr;
  logic [SYMBOL_BITS-1:0] px;
  logic              lastp;
  logic [WORD_W-1:0] rdata;

  logic              accept;
  logic [3:0]        act_eff;
  logic [SYMBOL_BITS-1:0] px_in;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              hit;
  logic [CODE_W-1:0] clear_code;
  logic [3:0]        cw1;
  logic [NFC_W-1:0]  nfc1;
  logic              bump;
  logic [2:0]        n;

  function automatic logic [3:0] clamp_size(input logic [3:0] v);
    if (v < 4'd2) return 4'd2;
    if (v > 4'(SYMBOL_BITS)) return 4'(SYMBOL_BITS);
    return v;
  endfunction

  assign pix_in.ready = (state == FR_RUN) && !q_status.full;
  assign accept       = pix_in.valid && pix_in.ready;
  assign act_eff      = started ? active : clamp_size(min_size);
  assign px_in        = pix_in.pixel[SYMBOL_BITS-1:0]
                        & ((SYMBOL_BITS'(1) << act_eff) - SYMBOL_BITS'(1));
  assign rd_addr      = {cur[IDX_W-1:0], px_in};
  assign hit          = (rdata[WORD_W-1 -: EPOCH_W] == epoch);
  assign clear_code   = CODE_W'(1) << active;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dict[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata <= dict[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FR_CLEAR;
      min_size <= MIN_SIZE_RESET;
      active   <= clamp_size(MIN_SIZE_RESET);
      started  <= 1'b0;
      cur      <= '0;
      nfc      <= '0;
      cw       <= '0;
      epoch    <= EPOCH_W'(1);
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      active   <= active_next;
      started  <= started_next;
      cur      <= cur_next;
      nfc      <= nfc_next;
      cw       <= cw_next;
      epoch    <= epoch_next;
      clr_addr <= clr_addr_next;
      if (cfg_wr_en) begin
        min_size <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px        <= px_in;
      lastp     <= pix_in.last_pixel;
      look_addr <= rd_addr;
    end
  end

  always_comb begin
    state_next    = state;
    active_next   = active;
    started_next  = started;
    cur_next      = cur;
    nfc_next      = nfc;
    cw_next       = cw;
    epoch_next    = epoch;
    clr_addr_next = clr_addr;
    mem_we        = 1'b0;
    mem_waddr     = look_addr;
    mem_wdata     = {epoch, nfc[CODE_W-1:0]};
    push          = 1'b0;
    push_entry    = '0;
    bump          = 1'b0;
    n             = 3'd0;
    cw1           = cw;
    nfc1          = nfc;
    case (state)
      FR_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = '0;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (&clr_addr) begin
          state_next = FR_RUN;
        end
      end
      FR_RUN: begin
        if (accept) begin
          state_next = FR_LOOK;
          if (!started) begin
            active_next = act_eff;
            cw_next     = act_eff + 4'd1;
            nfc_next    = (NFC_W'(1) << act_eff) + NFC_W'(2);
          end
        end
      end
      FR_LOOK: begin
        state_next = FR_RUN;
        if (!started) begin
          started_next = 1'b1;
          cur_next     = CODE_W'(px);
          push_entry.code[n[1:0]]  = clear_code;
          push_entry.width[n[1:0]] = cw;
          n = n + 3'd1;
        end else if (hit) begin
          cur_next = rdata[CODE_W-1:0];
        end else begin
          push_entry.code[n[1:0]]  = cur;
          push_entry.width[n[1:0]] = cw;
          n = n + 3'd1;
          if (nfc < NFC_W'(MAX_CODES)) begin
            mem_we = 1'b1;
          end
          cw1      = (nfc >= (NFC_W'(1) << cw)) ? cw + 4'd1 : cw;
          nfc1     = nfc + NFC_W'(1);
          cw_next  = cw1;
          nfc_next = nfc1;
          if (nfc1 >= NFC_W'(MAX_CODES)) begin
            push_entry.code[n[1:0]]  = clear_code;
            push_entry.width[n[1:0]] = cw1;
            n = n + 3'd1;
            bump     = 1'b1;
            cw_next  = active + 4'd1;
            nfc_next = NFC_W'(clear_code) + NFC_W'(2);
          end
          cur_next = CODE_W'(px);
        end
        if (lastp) begin
          push_entry.code[n[1:0]]  = cur_next;
          push_entry.width[n[1:0]] = cw_next;
          n = n + 3'd1;
          push_entry.code[n[1:0]]  = clear_code + CODE_W'(1);
          push_entry.width[n[1:0]] = cw_next;
          n = n + 3'd1;
          push_entry.flush = 1'b1;
          started_next = 1'b0;
          cur_next     = '0;
          bump         = 1'b1;
        end
        push_entry.count = n;
        push = (n != 3'd0);
        // tag wrap: sweep the store before reuse
        if (bump) begin
          if (&epoch) begin
            epoch_next = EPOCH_W'(1);
            state_next = FR_CLEAR;
          end else begin
            epoch_next = epoch + EPOCH_W'(1);
          end
        end
      end
      default: begin
        state_next = FR_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/glzw_queue.sv =====
// ----------------------------------------------------------------------------
// glzw_queue
// Short FIFO of code requests between front and back.
// ----------------------------------------------------------------------------
module glzw_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  glzw_pkg::emit_t     push_entry,
  input  logic                pop,
  output glzw_pkg::emit_t     head,
  output glzw_pkg::q_status_t q_status
);
  import glzw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  emit_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign head           = slots[rd_ptr];
  assign q_status.full  = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/glzw_back.sv =====
// ----------------------------------------------------------------------------
// glzw_back
// Bit packer: appends codes LSB first and hands out whole bytes; on a flush the last partial byte is padded with zeros.
// ----------------------------------------------------------------------------
module glzw_back (
  input  logic                clk,
  input  logic                rst,
  input  glzw_pkg::emit_t     head,
  input  glzw_pkg::q_status_t q_status,
  output logic                pop,
  glzw_byte_if.source         byte_out
);
  import glzw_pkg::*;

  localparam int ACC_W = CODE_W + 7;

  logic [ACC_W-1:0]  acc;
  logic [4:0]        cnt;
  logic [2:0]        k;
  logic              ovalid;
  logic [7:0]        obyte;
  logic              olast;

  logic              have;
  logic              left;
  logic              fin_flush;
  logic              byte_rdy;
  logic              load;
  logic [WIDTH_W-1:0] wsel;
  logic [CODE_W-1:0] code_m;

  assign have      = !q_status.empty;
  assign left      = have && (k < head.count);
  assign fin_flush = have && !left && head.flush;
  assign byte_rdy  = (cnt >= 5'd8) || (fin_flush && (cnt != 5'd0));
  assign load      = !ovalid || byte_out.ready;
  assign wsel      = head.width[k[1:0]];
  assign code_m    = head.code[k[1:0]] & ((CODE_W'(1) << wsel) - CODE_W'(1));
  assign pop       = have && !left && (head.flush ? (cnt == 5'd0) : (cnt < 5'd8));

  assign byte_out.valid     = ovalid;
  assign byte_out.out_byte  = obyte;
  assign byte_out.last_byte = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      cnt    <= '0;
      k      <= '0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        ovalid <= byte_rdy;
      end
      if (load && byte_rdy) begin
        acc <= acc >> 8;
        cnt <= (cnt >= 5'd8) ? cnt - 5'd8 : 5'd0;
      end else if (left && (cnt < 5'd8)) begin
        acc <= acc | (ACC_W'(code_m) << cnt[2:0]);
        cnt <= cnt + 5'(wsel);
        k   <= k + 3'd1;
      end
      if (pop) begin
        k <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && byte_rdy) begin
      obyte <= acc[7:0];
      olast <= fin_flush && (cnt <= 5'd8);
    end
  end

endmodule

// ===== hw/rtl/gif_lzw_encoder_core.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_encoder_core
// GIF-style LZW encoder: palette pixels in, LSB-first packed bytes out.
// A new pixel is taken only after the dictionary read of the last one and
// the write before the next lookup, and not while the request queue is full.
// The packer moves one code or one byte per cycle while the output is not stalled.
// Reset: a sweep over all 2^(log2(MAX_CODES)+SYMBOL_BITS) entries clears the
// dictionary; the same sweep runs after every 1023 dictionary clears or image ends.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_core #(
  parameter int MAX_CODES   = glzw_pkg::MAX_CODES_DEF,
  parameter int SYMBOL_BITS = glzw_pkg::SYMBOL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  glzw_pix_if.sink   pix_in,
  glzw_byte_if.source byte_out
);
  import glzw_pkg::*;

  logic      push;
  emit_t     push_entry;
  logic      pop;
  emit_t     head;
  q_status_t q_status;

  glzw_front #(
    .MAX_CODES  (MAX_CODES),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .pix_in     (pix_in),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  glzw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  glzw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_status(q_status),
    .pop     (pop),
    .byte_out(byte_out)
  );

endmodule

// ===== hw/rtl/glzw_checker.sv =====
// ----------------------------------------------------------------------------
// glzw_checker
// Port-level checks of the encoder core, bound to the top level.
// ----------------------------------------------------------------------------
module glzw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // reset starts the clearing sweep
  a_reset_no_ready: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  a_reset_no_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // lookup occupies the cycle after a request
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken during lookup");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(last_byte)))
    else $error("stalled output changed");

endmodule

bind gif_lzw_encoder_core glzw_checker u_glzw_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (pix_in.valid),
  .in_ready (pix_in.ready),
  .out_valid(byte_out.valid),
  .out_ready(byte_out.ready),
  .out_byte (byte_out.out_byte),
  .last_byte(byte_out.last_byte)
);
